@@ hw/rtl/aqie_pkg.sv @@
`timescale 1ns / 1ps

package aqie_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_CALC,
        ST_OUT
    } aqie_state_t;

    // humidity comfort band, in 1/1024 %RH
    localparam int HUM_LOW  = 38912;
    localparam int HUM_HIGH = 43008;

    // 6553600 / 38912 = 3200 / 19, 6553600 / 59392 = 3200 / 29
    localparam int HUM_SCALE    = 3200;
    localparam int HUM_DIV_LOW  = 19;
    localparam int HUM_DIV_HIGH = 29;

    localparam int Q16_ONE      = 65536;
    localparam int SCORE_FULL   = 6553600;
    localparam int GAS_WEIGHT   = 300;        // 3 * 100, integer gas score weight on the Q16 ratio
    localparam int IAQ_TOP      = 131072000;  // 500 * 2^18
    localparam int IAQ_GAIN     = 5;

    localparam int CO2_BASE     = 400;
    localparam int CO2_SPAN     = 4600;
    localparam int VOC_SPAN     = 6400;

    localparam int ACC_LVL1     = 5;
    localparam int ACC_LVL2     = 15;
    localparam int ACC_LVL3     = 30;

    localparam int BASELINE_RESET = 100000;

    localparam int RATIO_STEPS  = 16;
    localparam int HUM_STEPS    = 29;
    localparam int STEP_W       = $clog2(HUM_STEPS);

endpackage

@@ hw/rtl/air_quality_index_estimator.sv @@
`timescale 1ns / 1ps

// channel   | dir | handshake           | payload
// ----------+-----+---------------------+------------------------------------------
// s_        | in  | s_tvalid / s_tready | s_tdata: gas_ohms, humidity_level
// m_        | out | m_tvalid / m_tready | m_tdata: iaq_score, accuracy_level,
//           |     |                     |          co2_ppm, voc_ppm_q8
// cfg_      | in  | cfg_wr_en           | cfg_wr_data: baseline_resistance
//
// Each accepted request runs the bit-serial division (the 29-bit humidity
// divider sets its length; the 16-bit ratio divider runs alongside), then the
// combine state and the load in ST_OUT, which waits until m_tdata is free.
// s_tready is high only in idle; a new request is taken while the previous
// result still waits on m_tready. Reset clears control state and loads the
// baseline register with 100000; no clearing pass is needed.

module air_quality_index_estimator
    import aqie_pkg::*;
#(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,     // [23:0] gas_ohms, [40:24] humidity_level

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,     // [8:0] iaq_score, [10:9] accuracy_level,
                                     // [23:11] co2_ppm, [36:24] voc_ppm_q8

    input  logic        cfg_wr_en,
    input  logic [23:0] cfg_wr_data
);

    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

    aqie_state_t state_reg, state_next;

    logic [23:0]       baseline_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [STEP_W-1:0] step_reg;

    // ratio divider
    logic [23:0] base_reg;
    logic [23:0] rrem_reg;
    logic [15:0] rq_reg;
    logic        rsat_reg;

    // humidity divider
    logic [28:0] hnum_reg;
    logic [4:0]  hdiv_reg;
    logic [4:0]  hrem_reg;
    logic [28:0] hq_reg;
    logic        hmid_reg;
    logic        hhigh_reg;

    logic [1:0]  acc_reg;
    logic [24:0] w_reg;
    logic [12:0] co2_reg;
    logic [12:0] voc_reg;

    logic        m_tvalid_reg;
    logic [39:0] m_tdata_reg;

    logic [23:0] in_gas;
    logic [16:0] in_hum;
    logic        in_fire;
    logic        out_free;

    assign in_gas   = s_tdata[23:0];
    assign in_hum   = s_tdata[40:24];
    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------- control ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_DIV;
            end
            ST_DIV: begin
                if (step_reg == STEP_W'(HUM_STEPS - 1)) state_next = ST_CALC;
            end
            ST_CALC: state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------- request capture ----------------
    logic        hum_low;
    logic        hum_high;
    logic [16:0] hum_off;
    logic [1:0]  acc_now;

    always_comb begin
        hum_low  = 32'(in_hum) < HUM_LOW;
        hum_high = 32'(in_hum) > HUM_HIGH;
        hum_off  = hum_low ? in_hum : in_hum - 17'(HUM_HIGH);
        if (32'(count_reg) >= ACC_LVL3)      acc_now = 2'd3;
        else if (32'(count_reg) >= ACC_LVL2) acc_now = 2'd2;
        else if (32'(count_reg) >= ACC_LVL1) acc_now = 2'd1;
        else                                 acc_now = 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            baseline_reg <= 24'(BASELINE_RESET);
            count_reg    <= '0;
        end else begin
            if (cfg_wr_en) baseline_reg <= cfg_wr_data;
            if (in_fire && count_reg < CNT_W'(BUFFER_DEPTH)) count_reg <= count_reg + 1'b1;
        end
    end

    // ---------------- serial dividers ----------------
    logic [24:0] rrem_sh;
    logic        rq_bit;
    logic [5:0]  hrem_sh;
    logic        hq_bit;

    always_comb begin
        rrem_sh = {rrem_reg, 1'b0};
        rq_bit  = rrem_sh >= {1'b0, base_reg};
        hrem_sh = {hrem_reg, hnum_reg[28]};
        hq_bit  = hrem_sh >= {1'b0, hdiv_reg};
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            base_reg  <= baseline_reg;
            rsat_reg  <= in_gas >= baseline_reg;
            rrem_reg  <= in_gas;
            rq_reg    <= '0;
            hnum_reg  <= 29'(hum_off) * 29'(HUM_SCALE);
            hdiv_reg  <= hum_low ? 5'(HUM_DIV_LOW) : 5'(HUM_DIV_HIGH);
            hrem_reg  <= '0;
            hq_reg    <= '0;
            hmid_reg  <= !hum_low && !hum_high;
            hhigh_reg <= hum_high;
            acc_reg   <= acc_now;
            step_reg  <= '0;
        end else if (state_reg == ST_DIV) begin
            step_reg <= step_reg + 1'b1;
            if (step_reg < STEP_W'(RATIO_STEPS)) begin
                rrem_reg <= rq_bit ? 24'(rrem_sh - {1'b0, base_reg}) : rrem_sh[23:0];
                rq_reg   <= {rq_reg[14:0], rq_bit};
            end
            hnum_reg <= {hnum_reg[27:0], 1'b0};
            hrem_reg <= hq_bit ? 5'(hrem_sh - {1'b0, hdiv_reg}) : hrem_sh[4:0];
            hq_reg   <= {hq_reg[27:0], hq_bit};
        end
    end

    // ---------------- combine ----------------
    logic [16:0]        ratio;
    logic [16:0]        inv;
    logic signed [26:0] hs_s;
    logic signed [26:0] gs_s;
    logic signed [26:0] w_s;
    logic [29:0]        co2_prod;
    logic [29:0]        voc_prod;

    always_comb begin
        ratio = rsat_reg ? 17'(Q16_ONE) : {1'b0, rq_reg};
        inv   = 17'(Q16_ONE) - ratio;
        if (hmid_reg)       hs_s = 27'(SCORE_FULL);
        else if (hhigh_reg) hs_s = 27'(SCORE_FULL) - $signed({3'b000, hq_reg[23:0]});
        else                hs_s = $signed({3'b000, hq_reg[23:0]});
        gs_s     = $signed({1'b0, 26'(26'(ratio) * 26'(GAS_WEIGHT))});
        w_s      = gs_s + hs_s;
        co2_prod = 30'(inv) * 30'(CO2_SPAN);
        voc_prod = 30'(inv) * 30'(VOC_SPAN);
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_CALC) begin
            w_reg   <= w_s[26] ? 25'd0 : w_s[24:0];
            co2_reg <= 13'(CO2_BASE) + co2_prod[28:16];
            voc_reg <= voc_prod[28:16];
        end
    end

    // ---------------- output register ----------------
    logic [26:0] t_val;
    logic        load;

    assign t_val = 27'(IAQ_TOP) - 27'(27'(w_reg) * 27'(IAQ_GAIN));
    assign load  = (state_reg == ST_OUT) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= {3'b000, voc_reg, co2_reg, acc_reg, t_val[26:18]};
        end
    end

    // ---------------- assertions ----------------
    a_fire_starts_div: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> (state_reg == ST_DIV) && (step_reg == '0))
        else $error("accepted request did not start division");

    a_iaq_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_tdata_reg[8:0] <= 9'd500))
        else $error("iaq_score out of range");

    a_co2_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_tdata_reg[23:11] >= 13'd400) && (m_tdata_reg[23:11] <= 13'd5000))
        else $error("co2_ppm out of range");

    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (step_reg <= STEP_W'(HUM_STEPS - 1)))
        else $error("division step counter overran");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(BUFFER_DEPTH))
        else $error("sample count passed buffer depth");

endmodule

@@ sim/air_quality_index_estimator_tb.sv @@
`timescale 1ns / 1ps

module air_quality_index_estimator_tb;
    import aqie_pkg::*;

    localparam int    DEPTH          = 64;
    localparam int    WATCHDOG_LIMIT = 5000;
    localparam int    DRAIN_CYCLES   = 40;
    localparam int    RANDOM_PER_SET = 128;
    localparam int    NUM_SETS       = 8;
    localparam longint HUM_FALL_SPAN = 59392;   // 100 %RH minus top of comfort band
    localparam longint Q18_UNIT      = 262144;
    localparam int    IAQ_MAX        = 500;

    typedef struct packed {
        logic [23:0] gas;
        logic [16:0] hum;
    } aq_sample_t;

    typedef struct packed {
        logic [8:0]  iaq;
        logic [1:0]  acc;
        logic [12:0] co2;
        logic [12:0] voc;
    } aq_reading_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata     = '0;     // [23:0] gas_ohms, [40:24] humidity_level
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [39:0] m_tdata;              // [8:0] iaq, [10:9] accuracy, [23:11] co2, [36:24] voc
    logic        cfg_wr_en   = 1'b0;
    logic [23:0] cfg_wr_data = '0;

    aq_sample_t  pending_samples[$];
    aq_reading_t expected_readings[$];
    aq_sample_t  cur_sample;

    logic [23:0] model_baseline = 24'(BASELINE_RESET);
    int unsigned model_count    = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          fails          = 0;
    int          samples_sent   = 0;
    int          readings_checked = 0;
    int          baseline_writes  = 0;
    int          quiet_cycles     = 0;

    air_quality_index_estimator #(
        .BUFFER_DEPTH(DEPTH)
    ) i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always #1 aclk = ~aclk;

    function automatic aq_reading_t predict_reading(input aq_sample_t smp,
                                                    input logic [23:0] base,
                                                    input int unsigned prior);
        aq_reading_t r;
        longint ratio;
        longint hum_score;
        longint weighted;
        longint headroom;
        longint inv;
        longint h;
        longint iaq;
        if (smp.gas >= base)
            ratio = Q16_ONE;
        else
            ratio = (longint'(smp.gas) <<< 16) / longint'(base);

        h = longint'(smp.hum);
        if (h < HUM_LOW)
            hum_score = h * SCORE_FULL / HUM_LOW;
        else if (h <= HUM_HIGH)
            hum_score = SCORE_FULL;
        else
            hum_score = SCORE_FULL - (h - HUM_HIGH) * SCORE_FULL / HUM_FALL_SPAN;

        weighted = GAS_WEIGHT * ratio + hum_score;
        if (weighted < 0)
            weighted = 0;
        if (weighted > IAQ_TOP)
            weighted = IAQ_TOP;
        headroom = IAQ_TOP - IAQ_GAIN * weighted;
        iaq = (headroom >= 0) ? headroom / Q18_UNIT : 0;
        if (iaq > IAQ_MAX)
            iaq = IAQ_MAX;
        r.iaq = 9'(iaq);

        // level reflects samples seen before this one
        if (prior >= ACC_LVL3)
            r.acc = 2'd3;
        else if (prior >= ACC_LVL2)
            r.acc = 2'd2;
        else if (prior >= ACC_LVL1)
            r.acc = 2'd1;
        else
            r.acc = 2'd0;

        inv   = Q16_ONE - ratio;
        r.co2 = 13'(CO2_BASE + ((inv * CO2_SPAN) >>> 16));
        r.voc = 13'((inv * VOC_SPAN) >>> 16);
        return r;
    endfunction

    function automatic logic [23:0] rand_gas(input logic [23:0] base);
        int unsigned pick;
        longint lo;
        longint hi;
        pick = $urandom_range(9);
        lo = longint'(base) - longint'(base) / 8;
        hi = longint'(base) + longint'(base) / 8;
        if (hi > 24'hFFFFFF)
            hi = 24'hFFFFFF;
        case (pick)
            0: return 24'd0;
            1: return 24'hFFFFFF;
            2: return base;
            3, 4, 5: begin
                if (base == 0)
                    return 24'($urandom);
                return 24'($urandom_range(int'(base) - 1));
            end
            6, 7: return 24'($urandom_range(int'(hi), int'(lo)));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [16:0] rand_humidity();
        int unsigned pick;
        pick = $urandom_range(9);
        case (pick)
            0: return 17'($urandom_range(HUM_HIGH, HUM_LOW));
            1, 2: return 17'($urandom_range(HUM_LOW - 1));
            3, 4, 5: return 17'($urandom_range(102400, HUM_HIGH + 1));
            6: return 17'($urandom_range(131071, 102401));   // above 100 %RH
            7: begin
                case ($urandom_range(5))
                    0: return 17'(HUM_LOW);
                    1: return 17'(HUM_LOW - 1);
                    2: return 17'(HUM_HIGH);
                    3: return 17'(HUM_HIGH + 1);
                    4: return 17'd0;
                    default: return 17'd102400;
                endcase
            end
            default: return 17'($urandom);
        endcase
    endfunction

    // sender: holds each request until taken, random gaps between requests
    always @(posedge aclk) begin : sample_driver
        logic busy;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            busy = s_tvalid;
            if (s_tvalid && s_tready) begin
                expected_readings.push_back(predict_reading(cur_sample, model_baseline,
                                                            model_count));
                if (model_count < DEPTH)
                    model_count++;
                samples_sent++;
                busy = 1'b0;
            end
            if (!busy) begin
                if (pending_samples.size() > 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                    cur_sample = pending_samples.pop_front();
                    s_tvalid  <= 1'b1;
                    s_tdata   <= {7'd0, cur_sample.hum, cur_sample.gas};
                end else begin
                    s_tvalid  <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : reading_monitor
        aq_reading_t got;
        aq_reading_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.iaq = m_tdata[8:0];
                got.acc = m_tdata[10:9];
                got.co2 = m_tdata[23:11];
                got.voc = m_tdata[36:24];
                if (expected_readings.size() == 0) begin
                    $error("unexpected reading: iaq %0d acc %0d co2 %0d voc %0d",
                           got.iaq, got.acc, got.co2, got.voc);
                    fails++;
                end else begin
                    want = expected_readings.pop_front();
                    readings_checked++;
                    if (got.iaq !== want.iaq) begin
                        $error("iaq_score: expected %0d, got %0d", want.iaq, got.iaq);
                        fails++;
                    end
                    if (got.acc !== want.acc) begin
                        $error("accuracy_level: expected %0d, got %0d", want.acc, got.acc);
                        fails++;
                    end
                    if (got.co2 !== want.co2) begin
                        $error("co2_ppm: expected %0d, got %0d", want.co2, got.co2);
                        fails++;
                    end
                    if (got.voc !== want.voc) begin
                        $error("voc_ppm_q8: expected %0d, got %0d", want.voc, got.voc);
                        fails++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin : watchdog
        if (!aresetn || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_sample(input logic [23:0] gas, input logic [16:0] hum);
        aq_sample_t smp;
        smp.gas = gas;
        smp.hum = hum;
        pending_samples.push_back(smp);
    endtask

    // every queued request taken and every reading back; checked at the falling
    // edge so the driver's updates from the rising edge have settled
    task automatic drain();
        do
            @(negedge aclk);
        while (pending_samples.size() > 0 || s_tvalid || expected_readings.size() > 0);
    endtask

    task automatic write_baseline(input logic [23:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        model_baseline = value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        baseline_writes++;
    endtask

    initial begin : stimulus
        logic [23:0] set_base [NUM_SETS];
        int          idle_mode;
        set_base[0] = 24'd1;
        set_base[1] = 24'hFFFFFF;
        set_base[2] = 24'd0;
        set_base[3] = 24'($urandom_range(24'hFFFFFF, 1));
        set_base[4] = 24'd7;
        set_base[5] = 24'(BASELINE_RESET);
        set_base[6] = 24'd65536;
        set_base[7] = 24'($urandom_range(2000000, 1000));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: corners of ratio and humidity band at reset baseline
        queue_sample(24'd0,        17'd0);
        queue_sample(24'hFFFFFF,   17'd102400);
        queue_sample(24'd100000,   17'd40000);
        queue_sample(24'd99999,    17'(HUM_LOW));
        queue_sample(24'd100001,   17'(HUM_HIGH));
        queue_sample(24'd50000,    17'(HUM_LOW - 1));
        queue_sample(24'd50000,    17'(HUM_HIGH + 1));
        queue_sample(24'd1,        17'h1FFFF);
        queue_sample(24'd75000,    17'd102400);
        queue_sample(24'd25000,    17'd20000);
        queue_sample(24'd99999,    17'h10000);
        queue_sample(24'hAAAAAA,   17'h15555);
        queue_sample(24'h555555,   17'h0AAAA);
        queue_sample(24'd0,        17'h1FFFF);
        queue_sample(24'd0,        17'(HUM_HIGH));
        queue_sample(24'hFFFFFF,   17'd0);
        queue_sample(24'd12345,    17'd102401);
        queue_sample(24'd90000,    17'd41000);
        queue_sample(24'd65536,    17'd1);
        queue_sample(24'd99000,    17'd60000);
        drain();

        for (int s = 0; s < NUM_SETS; s++) begin
            write_baseline(set_base[s]);
            idle_mode = s % 4;
            send_idle_pct  = (idle_mode == 1) ? 67 : (idle_mode == 3) ? 9 : 0;
            recv_stall_pct = (idle_mode == 2) ? 67 : (idle_mode == 3) ? 9 : 0;
            for (int k = 0; k < RANDOM_PER_SET; k++) begin
                queue_sample(rand_gas(set_base[s]), rand_humidity());
                // sender holds off mid-set until the block has fully emptied
                if (s == 3 && k == RANDOM_PER_SET / 2)
                    drain();
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d samples across %0d baseline writes incl. 0, 1 and full scale",
                 samples_sent, baseline_writes);
        $display("Checked %0d readings under free-running, sender-gap and receiver-stall traffic",
                 readings_checked);
        if (fails == 0 && expected_readings.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/aqie_pkg.sv
hw/rtl/air_quality_index_estimator.sv
sim/air_quality_index_estimator_tb.sv
